### hdl/small_cpu_execute_unit_macros.svh
// Assertion macros shared by the checker files of the execute unit.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef SMALL_CPU_EXECUTE_UNIT_MACROS_SVH
`define SMALL_CPU_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCPU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("execute unit check failed");

// Next-cycle implication, checked outside reset.
`define SCPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit check failed");

`endif

### hdl/scpu_pkg.sv
// Shared types, constants and helper functions of the small CPU execute unit.
// Depends on nothing; the front, queue, back, top and checker files use it by scoped names.
package scpu_pkg;

    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
    localparam logic [23:0] PC_STEP = 24'd4;

    typedef enum logic [3:0] {
        OP_HALT   = 4'd0,
        OP_JMP    = 4'd1,
        OP_JC     = 4'd2,
        OP_JO     = 4'd3,
        OP_LOAD   = 4'd4,
        OP_STORE  = 4'd5,
        OP_LDI    = 4'd6,
        OP_NOP    = 4'd7,
        OP_ADD    = 4'd8,
        OP_SUB    = 4'd9,
        OP_INPUT  = 4'd10,
        OP_OUTPUT = 4'd11,
        OP_EQ     = 4'd12,
        OP_LT     = 4'd13,
        OP_LE     = 4'd14,
        OP_INVC   = 4'd15
    } opcode_t;

    typedef struct packed {
        logic [31:0]        instruction_word;
        logic signed [15:0] load_data;
        logic [7:0]         in_byte;
    } in_t;

    typedef struct packed {
        logic [23:0]        next_pc;
        logic               halted;
        logic               store_valid;
        logic [23:0]        store_addr;
        logic signed [15:0] store_data;
        logic               out_valid;
        logic [7:0]         out_byte;
        logic               overflow_flag;
        logic               compare_flag;
    } out_t;

    // Decoded instruction as it travels from the front to the back.
    typedef struct packed {
        opcode_t                op;
        logic [REG_IDX_W-1:0]   wr_idx;
        logic [REG_IDX_W-1:0]   rd0_idx;
        logic [REG_IDX_W-1:0]   rd1_idx;
        logic [23:0]            addr;
        logic [15:0]            imm;
        logic signed [15:0]     load_data;
        logic [7:0]             in_byte;
    } dec_t;

    // Reduces a 4-bit register field modulo REG_COUNT by repeated subtraction.
    function automatic logic [REG_IDX_W-1:0] reg_sel(input logic [3:0] nib);
        logic [4:0] v;
        v = {1'b0, nib};
        for (int i = 0; i < 8; i++) begin
            if (v >= 5'(REG_COUNT)) begin
                v = v - 5'(REG_COUNT);
            end
        end
        return v[REG_IDX_W-1:0];
    endfunction

endpackage

### hdl/scpu_ram.sv
// Generic RAM with one write port and one registered read port.
// Depends on nothing.
module scpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/scpu_front.sv
// Front end: takes input items and decodes them into register-file read and write indices.
// Depends on scpu_pkg.
module scpu_front (
    input  logic           push,
    input  scpu_pkg::in_t  request,
    output logic           full,
    input  logic           queue_full,
    output logic           queue_wr,
    output scpu_pkg::dec_t dec
);

    logic [31:0] word;
    logic        two_src;

    assign word     = request.instruction_word;
    assign full     = queue_full;
    assign queue_wr = push && !queue_full;

    always_comb
    begin
        dec.op        = scpu_pkg::opcode_t'(word[31:28]);
        dec.wr_idx    = scpu_pkg::reg_sel(word[27:24]);
        dec.addr      = word[23:0];
        dec.imm       = word[15:0];
        dec.load_data = request.load_data;
        dec.in_byte   = request.in_byte;
        // Add and sub read b and c; everything else reads a and b.
        two_src = (dec.op inside {scpu_pkg::OP_ADD, scpu_pkg::OP_SUB});
        if (two_src)
        begin
            dec.rd0_idx = scpu_pkg::reg_sel(word[23:20]);
            dec.rd1_idx = scpu_pkg::reg_sel(word[19:16]);
        end
        else
        begin
            dec.rd0_idx = scpu_pkg::reg_sel(word[27:24]);
            dec.rd1_idx = scpu_pkg::reg_sel(word[23:20]);
        end
    end

endmodule

### hdl/scpu_queue.sv
// Short queue of decoded items between the front and back ends.
// Depends on scpu_pkg.
module scpu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  scpu_pkg::dec_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output scpu_pkg::dec_t rd_data,
    output logic           empty
);

    scpu_pkg::dec_t                     slot_reg [scpu_pkg::QUEUE_DEPTH];
    logic [scpu_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [scpu_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [scpu_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == scpu_pkg::QUEUE_CNT_W'(scpu_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == scpu_pkg::QUEUE_PTR_W'(scpu_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == scpu_pkg::QUEUE_PTR_W'(scpu_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/scpu_back.sv
// Back end: register-file read, execute, architectural state and the result queue.
// Depends on scpu_pkg and scpu_ram.
module scpu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  scpu_pkg::dec_t q_data,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output scpu_pkg::out_t result
);

    localparam int IW = scpu_pkg::REG_IDX_W;

    // Execute stage.
    logic                 s2_valid_reg;
    scpu_pkg::dec_t       s2_dec_reg;
    logic                 fwd0_reg, fwd1_reg;
    logic                 valid0_reg, valid1_reg;
    logic [15:0]          fwd_data_reg;

    // Architectural state.
    logic [scpu_pkg::REG_COUNT-1:0] rf_valid_reg, rf_valid_next;
    logic [23:0]          pc_reg, pc_next;
    logic                 ovf_reg, ovf_next;
    logic                 cmp_reg, cmp_next;
    logic                 stopped_reg, stopped_next;

    // Result queue.
    scpu_pkg::out_t                 oq_reg [scpu_pkg::OUT_DEPTH];
    logic [scpu_pkg::OUT_PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [scpu_pkg::OUT_CNT_W-1:0] oq_cnt_reg;

    logic                 s2_fire, issue, pop_fire;
    logic                 we;
    logic [15:0]          wdata;
    logic [15:0]          ram0, ram1;
    logic signed [15:0]   opa, opb, sum, diff;
    scpu_pkg::out_t       res;

    assign s2_fire  = s2_valid_reg
                   && (oq_cnt_reg != scpu_pkg::OUT_CNT_W'(scpu_pkg::OUT_DEPTH));
    assign issue    = !q_empty && (!s2_valid_reg || s2_fire);
    assign q_pop    = issue;
    assign pop_fire = pop && !empty;
    assign empty    = (oq_cnt_reg == '0);
    assign result   = oq_reg[oq_rd_reg];

    scpu_ram #(.WIDTH(16), .DEPTH(scpu_pkg::REG_COUNT)) u_ram0 (
        .clk   (clk),
        .we    (we),
        .waddr (s2_dec_reg.wr_idx),
        .wdata (wdata),
        .re    (issue),
        .raddr (q_data.rd0_idx),
        .rdata (ram0)
    );

    scpu_ram #(.WIDTH(16), .DEPTH(scpu_pkg::REG_COUNT)) u_ram1 (
        .clk   (clk),
        .we    (we),
        .waddr (s2_dec_reg.wr_idx),
        .wdata (wdata),
        .re    (issue),
        .raddr (q_data.rd1_idx),
        .rdata (ram1)
    );

    // A write in the cycle of the read is forwarded; an entry never written reads as zero.
    assign opa  = fwd0_reg ? fwd_data_reg : (valid0_reg ? ram0 : 16'd0);
    assign opb  = fwd1_reg ? fwd_data_reg : (valid1_reg ? ram1 : 16'd0);
    assign sum  = opa + opb;
    assign diff = opa - opb;

    always_comb
    begin
        pc_next      = pc_reg;
        ovf_next     = ovf_reg;
        cmp_next     = cmp_reg;
        stopped_next = stopped_reg;
        we           = 1'b0;
        wdata        = 16'd0;
        res          = '0;
        if (s2_fire && !stopped_reg)
        begin
            pc_next = pc_reg + scpu_pkg::PC_STEP;
            case (s2_dec_reg.op)
                scpu_pkg::OP_HALT:   stopped_next = 1'b1;
                scpu_pkg::OP_JMP:    pc_next = s2_dec_reg.addr;
                scpu_pkg::OP_JC:     if (cmp_reg) pc_next = s2_dec_reg.addr;
                scpu_pkg::OP_JO:     if (ovf_reg) pc_next = s2_dec_reg.addr;
                scpu_pkg::OP_LOAD:
                begin
                    we    = 1'b1;
                    wdata = s2_dec_reg.load_data;
                end
                scpu_pkg::OP_STORE:
                begin
                    res.store_valid = 1'b1;
                    res.store_addr  = s2_dec_reg.addr;
                    res.store_data  = opa;
                end
                scpu_pkg::OP_LDI:
                begin
                    we    = 1'b1;
                    wdata = s2_dec_reg.imm;
                end
                scpu_pkg::OP_NOP:    ;
                scpu_pkg::OP_ADD:
                begin
                    we       = 1'b1;
                    wdata    = sum;
                    ovf_next = (opa[15] == opb[15]) && (sum[15] != opa[15]);
                end
                scpu_pkg::OP_SUB:
                begin
                    we       = 1'b1;
                    wdata    = diff;
                    ovf_next = (opa[15] != opb[15]) && (diff[15] != opa[15]);
                end
                scpu_pkg::OP_INPUT:
                begin
                    we    = 1'b1;
                    wdata = {opa[15:8], s2_dec_reg.in_byte};
                end
                scpu_pkg::OP_OUTPUT:
                begin
                    res.out_valid = 1'b1;
                    res.out_byte  = opa[7:0];
                end
                scpu_pkg::OP_EQ:     cmp_next = (opa == opb);
                scpu_pkg::OP_LT:     cmp_next = (opa < opb);
                scpu_pkg::OP_LE:     cmp_next = (opa <= opb);
                default:             cmp_next = !cmp_reg;
            endcase
        end
        res.next_pc       = pc_next;
        res.halted        = stopped_next;
        res.overflow_flag = ovf_next;
        res.compare_flag  = cmp_next;
    end

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (we)
        begin
            rf_valid_next[s2_dec_reg.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            rf_valid_reg <= '0;
            pc_reg       <= '0;
            ovf_reg      <= 1'b0;
            cmp_reg      <= 1'b0;
            stopped_reg  <= 1'b0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_cnt_reg   <= '0;
        end
        else
        begin
            if (issue)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
            rf_valid_reg <= rf_valid_next;
            pc_reg       <= pc_next;
            ovf_reg      <= ovf_next;
            cmp_reg      <= cmp_next;
            stopped_reg  <= stopped_next;
            if (s2_fire)
            begin
                oq_wr_reg <= (oq_wr_reg == scpu_pkg::OUT_PTR_W'(scpu_pkg::OUT_DEPTH - 1))
                           ? '0 : oq_wr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                oq_rd_reg <= (oq_rd_reg == scpu_pkg::OUT_PTR_W'(scpu_pkg::OUT_DEPTH - 1))
                           ? '0 : oq_rd_reg + 1'b1;
            end
            if (s2_fire && !pop_fire)
            begin
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            end
            else if (pop_fire && !s2_fire)
            begin
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_dec_reg   <= q_data;
            fwd0_reg     <= we && (s2_dec_reg.wr_idx == q_data.rd0_idx);
            fwd1_reg     <= we && (s2_dec_reg.wr_idx == q_data.rd1_idx);
            valid0_reg   <= rf_valid_reg[q_data.rd0_idx[IW-1:0]];
            valid1_reg   <= rf_valid_reg[q_data.rd1_idx[IW-1:0]];
            fwd_data_reg <= wdata;
        end
        if (s2_fire)
        begin
            oq_reg[oq_wr_reg] <= res;
        end
    end

endmodule

### hdl/small_cpu_execute_unit.sv
// Top level of the small CPU execute unit: front decode, decoded-item queue, back end.
// Depends on scpu_pkg, scpu_front, scpu_queue and scpu_back.

// The unit executes one instruction per item and sustains one item per clock cycle when
// pop keeps up. An accepted item is first held in the decoded-item queue; as it leaves
// the queue for the execute stage the registered read of the register file is launched,
// and the execute stage then writes the result into the result queue that drives the
// result ports. The register file is a pair of small RAMs with a registered read; a value
// written by one instruction is forwarded to the next, so dependent instructions still
// run back to back. Reset clears the register file at once through per-register valid
// bits, so there is no clearing pass. After a halt every item still gives one result that
// repeats the held program counter and flags.
module small_cpu_execute_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  scpu_pkg::in_t  request,
    output logic           empty,
    input  logic           pop,
    output scpu_pkg::out_t result
);

    scpu_pkg::dec_t dec;
    scpu_pkg::dec_t q_data;
    logic           queue_wr;
    logic           queue_full;
    logic           q_empty;
    logic           q_pop;

    scpu_front u_front (
        .push       (push),
        .request    (request),
        .full       (full),
        .queue_full (queue_full),
        .queue_wr   (queue_wr),
        .dec        (dec)
    );

    scpu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (queue_wr),
        .wr_data (dec),
        .full    (queue_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    scpu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### hdl/scpu_checker.sv
// Port-level checks of the execute unit, bound to the top level.
// Depends on scpu_pkg and small_cpu_execute_unit_macros.svh.
`include "small_cpu_execute_unit_macros.svh"

module scpu_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           push,
    input logic           full,
    input scpu_pkg::in_t  request,
    input logic           empty,
    input logic           pop,
    input scpu_pkg::out_t result
);

    // Once halted, every later result is halted as well.
    `SCPU_ASSERT_NEXT(a_halt_sticks, pop && !empty && result.halted, empty || result.halted)

    // A halted result never carries a store or an output byte.
    `SCPU_ASSERT_NOW(a_halt_quiet, !empty && result.halted, !result.store_valid && !result.out_valid)

    // One instruction cannot both store and output.
    `SCPU_ASSERT_NOW(a_one_effect, !empty, !(result.store_valid && result.out_valid))

    // Store fields read as zero without a store.
    `SCPU_ASSERT_NOW(a_store_zero, !empty && !result.store_valid, result.store_addr == 24'd0 && result.store_data == 16'sd0)

    // A waiting result stays put until it is taken.
    `SCPU_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result))

endmodule

bind small_cpu_execute_unit scpu_checker u_checker (.*);
